// File: hw/rtl/bms_response_frame_checker_defines.svh
// Assertion macros shared by the response frame checker RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef BMS_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define BMS_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define BMSRFC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Condition must hold in the cycle after the trigger.
`define BMSRFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: hw/rtl/bmsrfc_pkg.sv
// Types, codes, constants and the CRC-16 byte update for the frame checker.
// No dependencies.
`default_nettype none

package bmsrfc_pkg;

   localparam int MAX_FRAME_DEF  = 256;
   localparam int DATA_DEPTH     = 12;
   localparam int DATA_IDX_W     = $clog2(DATA_DEPTH);
   localparam int DATA_FIRST     = 4;       // frame index of first captured data byte
   localparam int MIN_FRAME      = 5;
   localparam int MIN_DATA       = 12;
   localparam int MIN_REGS       = MIN_DATA / 2;
   localparam int FRAME_BYTES_W  = 9;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  FUNC_READ      = 8'h03;
   localparam logic [7:0]  FUNC_EXCEPTION = 8'h03 | 8'h80;

   typedef enum logic {
      CMD_BYTE    = 1'b0,
      CMD_TIMEOUT = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_RESPONSE = 3'd1,
      ST_TOO_SHORT   = 3'd2,
      ST_CRC_ERROR   = 3'd3,
      ST_EXCEPTION   = 3'd4,
      ST_BAD_FUNC    = 3'd5,
      ST_SHORT_DATA  = 3'd6
   } status_type;

   // Everything the back end needs to judge one finished frame.
   typedef struct packed {
      logic                          timeout;
      logic [FRAME_BYTES_W-1:0]      frame_bytes;
      logic [15:0]                   crc;
      logic [15:0]                   tail;
      logic [7:0]                    func;
      logic [15:0]                   header;
      logic [DATA_DEPTH-1:0][7:0]    data;
   } frame_sum_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bmsrfc_front.sv
// Front end: takes received bytes, runs the CRC, captures header and data bytes,
// and hands a frame summary to the queue at frame end or timeout. Uses bmsrfc_pkg.
`default_nettype none

module bmsrfc_front #(
   parameter int MAX_FRAME = bmsrfc_pkg::MAX_FRAME_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic                    in_command,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    in_last,
   output logic                         push,
   output bmsrfc_pkg::frame_sum_type    push_data,
   input  wire logic                    queue_full
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [15:0]       tail_ff, tail_in;
   logic [7:0]        func_ff, func_in;
   logic [15:0]       header_ff, header_in;
   logic [bmsrfc_pkg::DATA_DEPTH-1:0][7:0] data_ff, data_in;

   logic             accept;
   logic             keep;
   logic [CNT_W-1:0] data_off;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign keep     = count_ff < CNT_W'(MAX_FRAME);
   assign data_off = count_ff - CNT_W'(bmsrfc_pkg::DATA_FIRST);

   // Frame state after this byte, before any end-of-frame clear.
   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      tail_in   = tail_ff;
      func_in   = func_ff;
      header_in = header_ff;
      data_in   = data_ff;
      if (keep) begin
         if (count_ff >= CNT_W'(2)) begin
            crc_in = bmsrfc_pkg::crc16_update(crc_ff, tail_ff[15:8]);
         end
         tail_in = {tail_ff[7:0], in_byte};
         if (count_ff == CNT_W'(1)) begin
            func_in = in_byte;
         end else if (count_ff == CNT_W'(2)) begin
            header_in[15:8] = in_byte;
         end else if (count_ff == CNT_W'(3)) begin
            header_in[7:0] = in_byte;
         end else if (count_ff >= CNT_W'(bmsrfc_pkg::DATA_FIRST) &&
                      count_ff < CNT_W'(bmsrfc_pkg::DATA_FIRST + bmsrfc_pkg::DATA_DEPTH)) begin
            data_in[data_off[bmsrfc_pkg::DATA_IDX_W-1:0]] = in_byte;
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      push_data             = '0;
      push_data.timeout     = (in_command == bmsrfc_pkg::CMD_TIMEOUT);
      if (in_command == bmsrfc_pkg::CMD_BYTE) begin
         push_data.frame_bytes = bmsrfc_pkg::FRAME_BYTES_W'(count_in);
         push_data.crc         = crc_in;
         push_data.tail        = tail_in;
         push_data.func        = func_in;
         push_data.header      = header_in;
         push_data.data        = data_in;
      end
   end

   assign push = accept && ((in_command == bmsrfc_pkg::CMD_TIMEOUT) || in_last);

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff  <= '0;
         crc_ff    <= bmsrfc_pkg::CRC_INIT;
         tail_ff   <= '0;
         func_ff   <= '0;
         header_ff <= '0;
         data_ff   <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         tail_ff   <= tail_in;
         func_ff   <= func_in;
         header_ff <= header_in;
         data_ff   <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bmsrfc_queue.sv
// Short FIFO of frame summaries between front and back end.
// Uses bmsrfc_pkg and the assertion macros header.
`default_nettype none
`include "bms_response_frame_checker_defines.svh"

module bmsrfc_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire bmsrfc_pkg::frame_sum_type push_data,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         not_empty,
   output bmsrfc_pkg::frame_sum_type    head
);

   localparam int DEPTH = bmsrfc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bmsrfc_pkg::frame_sum_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   `BMSRFC_ASSERT_SAME(a_no_overflow, clock, reset, push, !full || pop)
   `BMSRFC_ASSERT_SAME(a_no_underflow, clock, reset, pop, not_empty)
   `BMSRFC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `BMSRFC_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop,
                       count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire

// File: hw/rtl/bmsrfc_back.sv
// Back end: judges a frame summary, decodes the status block and holds the
// result in the output register until taken. Uses bmsrfc_pkg.
`default_nettype none

module bmsrfc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    sum_valid,
   input  wire bmsrfc_pkg::frame_sum_type sum,
   output logic                         pop,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output bmsrfc_pkg::status_type       out_status,
   output logic [7:0]                   out_exception,
   output logic [15:0]                  out_reg_count,
   output logic [15:0]                  out_charge,
   output logic [15:0]                  out_discharge,
   output logic [15:0]                  out_voltage,
   output logic [15:0]                  out_soc,
   output logic [31:0]                  out_capacity,
   output logic [bmsrfc_pkg::FRAME_BYTES_W-1:0] out_frame_bytes
);

   logic                   valid_ff;
   bmsrfc_pkg::status_type status_ff, status_in;
   logic [7:0]             exc_ff, exc_in;
   logic [15:0]            regs_ff, regs_in;
   logic [15:0]            chg_ff, chg_in;
   logic [15:0]            dis_ff, dis_in;
   logic [15:0]            volt_ff, volt_in;
   logic [15:0]            soc_ff, soc_in;
   logic [31:0]            cap_ff, cap_in;
   logic [bmsrfc_pkg::FRAME_BYTES_W-1:0] nbytes_ff, nbytes_in;
   logic [15:0]            recv_crc;

   // CRC travels low byte first, so the older tail byte is the low half.
   assign recv_crc = {sum.tail[7:0], sum.tail[15:8]};
   assign pop      = sum_valid && (!valid_ff || out_ready);

   always_comb begin
      status_in = bmsrfc_pkg::ST_OK;
      exc_in    = '0;
      regs_in   = '0;
      chg_in    = '0;
      dis_in    = '0;
      volt_in   = '0;
      soc_in    = '0;
      cap_in    = '0;
      nbytes_in = sum.frame_bytes;
      if (sum.timeout) begin
         status_in = bmsrfc_pkg::ST_NO_RESPONSE;
         nbytes_in = '0;
      end else if (sum.frame_bytes < bmsrfc_pkg::FRAME_BYTES_W'(bmsrfc_pkg::MIN_FRAME)) begin
         status_in = bmsrfc_pkg::ST_TOO_SHORT;
      end else if (sum.crc != recv_crc) begin
         status_in = bmsrfc_pkg::ST_CRC_ERROR;
      end else if (sum.func == bmsrfc_pkg::FUNC_EXCEPTION) begin
         status_in = bmsrfc_pkg::ST_EXCEPTION;
         exc_in    = sum.header[15:8];
      end else if (sum.func == bmsrfc_pkg::FUNC_READ) begin
         regs_in = sum.header;
         if (sum.header < 16'(bmsrfc_pkg::MIN_REGS)) begin
            status_in = bmsrfc_pkg::ST_SHORT_DATA;
         end else begin
            chg_in  = {sum.data[0], sum.data[1]};
            dis_in  = {sum.data[2], sum.data[3]};
            volt_in = {sum.data[4], sum.data[5]};
            soc_in  = {sum.data[6], sum.data[7]};
            cap_in  = {sum.data[8], sum.data[9], sum.data[10], sum.data[11]};
         end
      end else begin
         status_in = bmsrfc_pkg::ST_BAD_FUNC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         exc_ff    <= exc_in;
         regs_ff   <= regs_in;
         chg_ff    <= chg_in;
         dis_ff    <= dis_in;
         volt_ff   <= volt_in;
         soc_ff    <= soc_in;
         cap_ff    <= cap_in;
         nbytes_ff <= nbytes_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_status      = status_ff;
   assign out_exception   = exc_ff;
   assign out_reg_count   = regs_ff;
   assign out_charge      = chg_ff;
   assign out_discharge   = dis_ff;
   assign out_voltage     = volt_ff;
   assign out_soc         = soc_ff;
   assign out_capacity    = cap_ff;
   assign out_frame_bytes = nbytes_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bms_response_frame_checker.sv
// Battery-monitor response frame checker: CRC-16 check and status decode.
// Throughput: one byte or timeout transfer per cycle while the queue is not full,
// set by the front end's combinational CRC byte update; a two-entry summary queue
// decouples the output. Path: frame summary queue, then back-end output register.
// Reset: synchronous, clears frame state, queue and output valid; no init pass.
`default_nettype none

module bms_response_frame_checker #(
   parameter int MAX_FRAME = bmsrfc_pkg::MAX_FRAME_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] command
   input  wire logic         req_tlast,   // frame_end
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] exception_code, [23:8] register_count, [39:24] charge_current,
   // [55:40] discharge_current, [71:56] module_voltage, [87:72] state_of_charge,
   // [119:88] capacity_mah, [128:120] frame_bytes, [135:129] zero
   output logic [135:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser    // [2:0] status
);

   logic                      push;
   bmsrfc_pkg::frame_sum_type push_data;
   logic                      queue_full;
   logic                      pop;
   logic                      sum_valid;
   bmsrfc_pkg::frame_sum_type head;

   bmsrfc_pkg::status_type    status;
   logic [7:0]                exc;
   logic [15:0]               regs, chg, dis, volt, soc;
   logic [31:0]               cap;
   logic [bmsrfc_pkg::FRAME_BYTES_W-1:0] nbytes;

   bmsrfc_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   bmsrfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (sum_valid),
      .head      (head)
   );

   bmsrfc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .sum_valid       (sum_valid),
      .sum             (head),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_status      (status),
      .out_exception   (exc),
      .out_reg_count   (regs),
      .out_charge      (chg),
      .out_discharge   (dis),
      .out_voltage     (volt),
      .out_soc         (soc),
      .out_capacity    (cap),
      .out_frame_bytes (nbytes)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {7'b0, nbytes, cap, soc, volt, dis, chg, regs, exc};

endmodule

`default_nettype wire
